@@ hdl/dsc_pkg.sv @@
// Shared types, constants and codes of the drawer slide controller.
`default_nettype none

package dsc_pkg;

  // Length of the pressure moving-average window.
  localparam int PRESS_WINDOW = 75;
  localparam int WIN_IDX_W    = $clog2(PRESS_WINDOW);

  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  // Slope filter arithmetic. The numerator 19*W*s + 65536*d + 10*W stays inside
  // a signed 32-bit word for every reachable slope value, since |s| <= 65536*1023/W + 10.
  localparam int SLOPE_W   = 32;
  localparam int DIFF_W    = 11;
  localparam logic signed [15:0] SLOPE_GAIN = 16'(19 * PRESS_WINDOW);
  localparam logic signed [SLOPE_W-1:0] SLOPE_BIAS = SLOPE_W'(10 * PRESS_WINDOW);

  // floor(N / (20*W)) is floor(floor(N / 4) / (5*W)). The quarter numerator is made
  // non-negative by a multiple of 5*W and divided by a reciprocal multiplication.
  localparam int DIV5         = 5 * PRESS_WINDOW;
  localparam int DIV5_W       = $clog2(DIV5);
  localparam int DIV_K        = 31 + DIV5_W;
  localparam int DIV_OFF_MULT = ((1 << 29) + DIV5 - 1) / DIV5;
  localparam int DIV_OFF      = DIV5 * DIV_OFF_MULT;
  localparam int DIV_IN_W     = 31;
  localparam int DIV_PROD_W   = DIV_IN_W + 32;
  localparam logic [31:0] DIV_RECIP =
      32'(((64'd1 << DIV_K) + 64'(DIV5) - 64'd1) / 64'(DIV5));
  localparam logic signed [SLOPE_W-1:0] DIV_BIAS_Q = SLOPE_W'(DIV_OFF_MULT);

  // Hall filter: floor((9*h + 256*x + 5) / 10) through a reciprocal multiplication.
  localparam int HALL_W       = 18;
  localparam int HALL_NUM_W   = 22;
  localparam int HALL_K       = HALL_NUM_W + 4;
  localparam int HALL_RECIP_W = HALL_K - 3;
  localparam int HALL_PROD_W  = HALL_NUM_W + HALL_RECIP_W;
  localparam logic [HALL_RECIP_W-1:0] HALL_RECIP =
      HALL_RECIP_W'(((64'd1 << HALL_K) + 64'd9) / 64'd10);

  // Position codes on the result.
  localparam logic [1:0] POS_CLOSED  = 2'd0;
  localparam logic [1:0] POS_OPENING = 2'd1;
  localparam logic [1:0] POS_OPENED  = 2'd2;
  localparam logic [1:0] POS_CLOSING = 2'd3;

  typedef enum logic [2:0] {
    CFG_OPEN_THRESHOLD   = 3'd0,
    CFG_CLOSED_THRESHOLD = 3'd1,
    CFG_SLOPE_THRESHOLD  = 3'd2,
    CFG_LOCKOUT_MS       = 3'd3,
    CFG_DRIVE_SPEED      = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    DRW_CLOSED  = 4'b0001,
    DRW_OPENING = 4'b0010,
    DRW_OPENED  = 4'b0100,
    DRW_CLOSING = 4'b1000
  } drw_e;

  typedef enum logic [2:0] {
    SEQ_IDLE   = 3'b001,
    SEQ_MULT   = 3'b010,
    SEQ_COMMIT = 3'b100
  } seq_e;

  typedef struct packed {
    logic        button_level;
    logic [9:0]  hall_sample;
    logic [9:0]  pressure_sample;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        open_drive;
    logic [7:0]        close_drive;
    logic [1:0]        position;
    logic              press_event;
    logic [HALL_W-1:0] hall_filtered;
  } out_item_t;

  typedef struct packed {
    logic [9:0]  open_threshold;
    logic [9:0]  closed_threshold;
    logic [16:0] press_slope_threshold;
    logic [15:0] press_lockout_ms;
    logic [7:0]  drive_speed;
  } cfg_t;

  // One classified tick between the front and the back.
  typedef struct packed {
    logic              button_level;
    logic [9:0]        hall_sample;
    logic [31:0]       now_ms;
    logic [DIFF_W-1:0] press_diff;
  } qent_t;

endpackage

`default_nettype wire

@@ hdl/dsc_front.sv @@
// Front end: accepts ticks, updates the pressure window and forms the sample change.
`default_nettype none

module dsc_front import dsc_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  output logic          push_o,
  output qent_t         push_data_o,
  input  wire logic     q_full_i
);

  logic [9:0]              win_mem [PRESS_WINDOW];
  logic [PRESS_WINDOW-1:0] win_vld_q;
  logic [WIN_IDX_W-1:0]    widx_q;
  logic [9:0]              old_q;
  logic                    old_vld_q;
  logic                    stg_vld_q;
  in_item_t                stg_q;
  logic                    accept;
  logic [9:0]              old_val;

  assign push_o     = stg_vld_q & ~q_full_i;
  assign in_ready_o = ~stg_vld_q | ~q_full_i;
  assign accept     = in_valid_i & in_ready_o;

  // Window entries never written since reset read as zero.
  assign old_val = old_vld_q ? old_q : '0;

  always_comb begin
    push_data_o.button_level = stg_q.button_level;
    push_data_o.hall_sample  = stg_q.hall_sample;
    push_data_o.now_ms       = stg_q.now_ms;
    push_data_o.press_diff   = DIFF_W'({1'b0, stg_q.pressure_sample})
                             - DIFF_W'({1'b0, old_val});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
      win_vld_q <= '0;
      widx_q    <= '0;
      old_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        stg_vld_q         <= 1'b1;
        old_vld_q         <= win_vld_q[widx_q];
        win_vld_q[widx_q] <= 1'b1;
        if (widx_q == WIN_IDX_W'(PRESS_WINDOW - 1)) begin
          widx_q <= '0;
        end else begin
          widx_q <= widx_q + WIN_IDX_W'(1);
        end
      end else if (push_o) begin
        stg_vld_q <= 1'b0;
      end
    end
  end

  // The read returns the sample that the write of the same edge replaces.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_q           <= in_item_i;
      old_q           <= win_mem[widx_q];
      win_mem[widx_q] <= in_item_i.pressure_sample;
    end
  end

endmodule

`default_nettype wire

@@ hdl/dsc_queue.sv @@
// Short queue of classified ticks between the front end and the back end.
`default_nettype none

module dsc_queue import dsc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire qent_t push_data_i,
  input  wire logic  pop_i,
  output qent_t      head_o,
  output logic       full_o,
  output logic       empty_o
);

  qent_t                  mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q;
  logic [QUEUE_CNT_W-1:0] cnt_q;

  assign full_o  = cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        if (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
          wr_ptr_q <= '0;
        end else begin
          wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
        end
      end
      if (pop_i) begin
        if (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
          rd_ptr_q <= '0;
        end else begin
          rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
        end
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QUEUE_CNT_W'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - QUEUE_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

@@ hdl/dsc_back.sv @@
// Back end: slope and hall filters, press detection, drawer state machine, result register.
`default_nettype none

module dsc_back import dsc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  q_empty_i,
  input  wire qent_t q_head_i,
  output logic       q_pop_o,
  input  wire cfg_t  cfg_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output out_item_t  out_item_o
);

  seq_e                      seq_q, seq_d;
  logic signed [SLOPE_W-1:0] slope_q, slope_new;
  logic [HALL_W-1:0]         hall_q, hall_new;
  logic                      holding_q, holding_d;
  logic [31:0]               last_press_q, last_press_d;
  logic                      armed_q, armed_d;
  drw_e                      drw_q, drw_d;
  logic [7:0]                open_q, open_d;
  logic [7:0]                close_q, close_d;

  logic signed [SLOPE_W-1:0] num_q, num_d;
  logic [HALL_NUM_W-1:0]     hnum_q, hnum_d;
  logic [DIV_PROD_W-1:0]     prod_q, prod_d;
  logic [HALL_PROD_W-1:0]    hprod_q, hprod_d;
  logic                      btn_q;
  logic [31:0]               now_q;

  logic                      out_valid_q;
  out_item_t                 out_q, out_d;

  logic signed [47:0]        gain_prod;
  logic [31:0]               biased;
  logic signed [SLOPE_W-1:0] thr_ext;
  logic                      slot_free;
  logic                      commit;
  logic                      press_evt;
  logic                      btn_edge;

  assign slot_free   = ~out_valid_q | out_ready_i;
  assign q_pop_o     = (seq_q == SEQ_IDLE) & ~q_empty_i;
  assign commit      = (seq_q == SEQ_COMMIT) & slot_free;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    seq_d = seq_q;
    case (seq_q)
      SEQ_IDLE: begin
        if (!q_empty_i) seq_d = SEQ_MULT;
      end
      SEQ_MULT: begin
        seq_d = SEQ_COMMIT;
      end
      SEQ_COMMIT: begin
        if (slot_free) seq_d = SEQ_IDLE;
      end
      default: begin
        seq_d = SEQ_IDLE;
      end
    endcase
  end

  // First step: filter numerators from the current state and the popped tick.
  always_comb begin
    gain_prod = 48'(SLOPE_GAIN) * 48'(slope_q);
    num_d     = SLOPE_W'(gain_prod)
              + (SLOPE_W'(signed'(q_head_i.press_diff)) <<< 16)
              + SLOPE_BIAS;
    hnum_d    = HALL_NUM_W'(hall_q) * HALL_NUM_W'(9)
              + HALL_NUM_W'({q_head_i.hall_sample, 8'b0})
              + HALL_NUM_W'(5);
  end

  // Second step: reciprocal multiplications.
  always_comb begin
    biased  = unsigned'(num_q >>> 2) + 32'(DIV_OFF);
    prod_d  = DIV_PROD_W'(biased[DIV_IN_W-1:0]) * DIV_PROD_W'(DIV_RECIP);
    hprod_d = HALL_PROD_W'(hnum_q) * HALL_PROD_W'(HALL_RECIP);
  end

  // Third step: new filter values, press detection and the drawer state machine.
  always_comb begin
    slope_new    = signed'(SLOPE_W'(prod_q >> DIV_K)) - DIV_BIAS_Q;
    hall_new     = HALL_W'(hprod_q >> HALL_K);
    thr_ext      = SLOPE_W'(signed'(cfg_i.press_slope_threshold));
    press_evt    = 1'b0;
    holding_d    = holding_q;
    last_press_d = last_press_q;
    if (slope_new < thr_ext) begin
      if (!holding_q && ((now_q - last_press_q) > {16'b0, cfg_i.press_lockout_ms})) begin
        press_evt    = 1'b1;
        holding_d    = 1'b1;
        last_press_d = now_q;
      end
    end else begin
      holding_d = 1'b0;
    end

    btn_edge = ~btn_q & armed_q;
    armed_d  = btn_q;

    drw_d   = drw_q;
    open_d  = open_q;
    close_d = close_q;
    case (drw_q)
      DRW_CLOSING: begin
        if (btn_edge) begin
          close_d = '0;
          open_d  = cfg_i.drive_speed;
          drw_d   = DRW_OPENING;
        end
        if (hall_new > {cfg_i.closed_threshold, 8'b0}) begin
          open_d  = '0;
          close_d = '0;
          drw_d   = DRW_CLOSED;
        end else if (press_evt) begin
          close_d = '0;
          open_d  = cfg_i.drive_speed;
          drw_d   = DRW_OPENING;
        end
      end
      DRW_OPENING: begin
        if (btn_edge) begin
          open_d  = '0;
          close_d = cfg_i.drive_speed;
          drw_d   = DRW_CLOSING;
        end
        // The end stop wins even over a reversal in the same tick.
        if (hall_new < {cfg_i.open_threshold, 8'b0}) begin
          open_d  = '0;
          close_d = '0;
          drw_d   = DRW_OPENED;
        end
      end
      DRW_CLOSED: begin
        if (btn_edge) begin
          close_d = '0;
          open_d  = cfg_i.drive_speed;
          drw_d   = DRW_OPENING;
        end
      end
      default: begin
        if (btn_edge) begin
          open_d  = '0;
          close_d = cfg_i.drive_speed;
          drw_d   = DRW_CLOSING;
        end
      end
    endcase

    out_d.open_drive    = open_d;
    out_d.close_drive   = close_d;
    out_d.press_event   = press_evt;
    out_d.hall_filtered = hall_new;
    case (drw_d)
      DRW_CLOSED:  out_d.position = POS_CLOSED;
      DRW_OPENING: out_d.position = POS_OPENING;
      DRW_OPENED:  out_d.position = POS_OPENED;
      DRW_CLOSING: out_d.position = POS_CLOSING;
      default:     out_d.position = POS_CLOSED;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q        <= SEQ_IDLE;
      slope_q      <= '0;
      hall_q       <= '0;
      holding_q    <= 1'b0;
      last_press_q <= '0;
      armed_q      <= 1'b1;
      drw_q        <= DRW_CLOSED;
      open_q       <= '0;
      close_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      seq_q <= seq_d;
      if (commit) begin
        slope_q      <= slope_new;
        hall_q       <= hall_new;
        holding_q    <= holding_d;
        last_press_q <= last_press_d;
        armed_q      <= armed_d;
        drw_q        <= drw_d;
        open_q       <= open_d;
        close_q      <= close_d;
        out_valid_q  <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      num_q  <= num_d;
      hnum_q <= hnum_d;
      btn_q  <= q_head_i.button_level;
      now_q  <= q_head_i.now_ms;
    end
    if (seq_q == SEQ_MULT) begin
      prod_q  <= prod_d;
      hprod_q <= hprod_d;
    end
    if (commit) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

@@ hdl/drawer_slide_controller.sv @@
// A tick passes the front stage, the queue, and then the pop, multiply and commit steps.
// The back end's three-step slope recurrence takes a new tick only after committing the last.
// The front end keeps taking ticks each cycle until its stage and the 2-entry queue are full.
// Reset (asynchronous, active low) clears the filters, the pressure window valid bits,
// the press state and the queue, arms the button edge detector and sets the drawer to closed with defaults.
`default_nettype none

module drawer_slide_controller import dsc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_item_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_item_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [16:0] cfg_data_i
);

  cfg_t  cfg_q;
  logic  q_push;
  qent_t q_push_data;
  logic  q_pop;
  qent_t q_head;
  logic  q_full;
  logic  q_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_threshold        <= 10'd499;
      cfg_q.closed_threshold      <= 10'd520;
      cfg_q.press_slope_threshold <= 17'(-11796);
      cfg_q.press_lockout_ms      <= 16'd300;
      cfg_q.drive_speed           <= 8'd255;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_OPEN_THRESHOLD:   cfg_q.open_threshold        <= cfg_data_i[9:0];
        CFG_CLOSED_THRESHOLD: cfg_q.closed_threshold      <= cfg_data_i[9:0];
        CFG_SLOPE_THRESHOLD:  cfg_q.press_slope_threshold <= cfg_data_i;
        CFG_LOCKOUT_MS:       cfg_q.press_lockout_ms      <= cfg_data_i[15:0];
        CFG_DRIVE_SPEED:      cfg_q.drive_speed           <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  dsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .push_o      (q_push),
    .push_data_o (q_push_data),
    .q_full_i    (q_full)
  );

  dsc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  dsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .q_pop_o     (q_pop),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_empty)
    else $error("back end popped an empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_full)
    else $error("front end pushed into a full queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && (out_item_o.position == POS_CLOSED || out_item_o.position == POS_OPENED)
      |-> out_item_o.open_drive == '0 && out_item_o.close_drive == '0)
    else $error("motor driven while the drawer is at rest");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> out_item_o.open_drive == '0 || out_item_o.close_drive == '0)
    else $error("both motor directions driven at once");

endmodule

`default_nettype wire
